// ===== design/pngcsv_pkg.sv =====
// Shared constants, types and byte-level helper functions of the PNG chunk stream validator.
package pngcsv_pkg;

  localparam int unsigned LengthBits = 32;
  localparam int unsigned StatusBits = 4;
  localparam int unsigned MarkerBits = 9;

  localparam logic [31:0] SigHi      = 32'h8950_4E47;
  localparam logic [31:0] SigLo      = 32'h0D0A_1A0A;
  localparam logic [31:0] TypeIhdr   = 32'h4948_4452;
  localparam logic [31:0] TypeIend   = 32'h4945_4E44;
  localparam logic [31:0] MarkerInit = 32'h6E69_4C4D;
  localparam logic [31:0] CrcInit    = 32'hFFFF_FFFF;
  localparam logic [31:0] CrcPoly    = 32'hEDB8_8320;

  localparam logic signed [MarkerBits-1:0] NoByte = '1;

  localparam logic [7:0] UpperFirst = 8'd65;
  localparam logic [7:0] UpperLast  = 8'd90;
  localparam logic [7:0] LowerFirst = 8'd97;
  localparam logic [7:0] LowerLast  = 8'd122;

  localparam logic [StatusBits-1:0] StEndOk     = 4'd0;
  localparam logic [StatusBits-1:0] StMarker    = 4'd1;
  localparam logic [StatusBits-1:0] StNotPng    = 4'd2;
  localparam logic [StatusBits-1:0] StBadType   = 4'd3;
  localparam logic [StatusBits-1:0] StNoHeader  = 4'd4;
  localparam logic [StatusBits-1:0] StCrc       = 4'd5;
  localparam logic [StatusBits-1:0] StShortSig  = 4'd6;
  localparam logic [StatusBits-1:0] StShortChnk = 4'd7;
  localparam logic [StatusBits-1:0] StNoIend    = 4'd8;

  localparam logic [2:0] RegStopAtMarker = 3'd0;
  localparam logic [2:0] RegMarkerType   = 3'd4;

  typedef struct packed {
    logic        stop_at_marker;
    logic [31:0] marker_type;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data_byte;
    logic       last_byte;
  } step_t;

  typedef struct packed {
    logic                           valid;
    logic [StatusBits-1:0]          status;
    logic signed [MarkerBits-1:0]   marker_byte;
  } verdict_t;

  // Reflected CRC-32 update by one byte, one bit per step.
  function automatic logic [31:0] crc_byte(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CrcPoly & {32{c[0]}});
    end
    return c;
  endfunction

  function automatic logic is_letter(logic [7:0] b);
    return ((b >= UpperFirst) && (b <= UpperLast)) || ((b >= LowerFirst) && (b <= LowerLast));
  endfunction

endpackage

// ===== design/pngcsv_if.sv =====
// Valid/ready stream interfaces for the input bytes and the verdicts.
interface pngcsv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface pngcsv_out_if;
  logic                                         valid;
  logic                                         ready;
  logic [pngcsv_pkg::StatusBits-1:0]            status;
  logic signed [pngcsv_pkg::MarkerBits-1:0]     marker_byte;

  modport source (output valid, output status, output marker_byte, input ready);
  modport sink (input valid, input status, input marker_byte, output ready);
endinterface

// ===== design/pngcsv_cfg.sv =====
// APB-style configuration registers: stop-at-marker enable and marker chunk type.
module pngcsv_cfg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output pngcsv_pkg::cfg_t   cfg_o
);
  import pngcsv_pkg::*;

  logic        stop_q;
  logic [31:0] marker_q;
  logic        wr_en;
  logic        sel_marker;

  assign pready     = 1'b1;
  assign wr_en      = psel && penable && pwrite;
  // Only the word-select bit decodes a register; byte offsets alias.
  assign sel_marker = paddr[2] == RegMarkerType[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_q   <= 1'b0;
      marker_q <= MarkerInit;
    end else if (wr_en) begin
      if (sel_marker) begin
        marker_q <= pwdata;
      end else begin
        stop_q <= pwdata[0];
      end
    end
  end

  assign prdata = sel_marker ? marker_q : {31'd0, stop_q};

  assign cfg_o.stop_at_marker = stop_q;
  assign cfg_o.marker_type    = marker_q;
endmodule

// ===== design/pngcsv_parser.sv =====
// Per-byte chunk parser: state registers, CRC, and the verdict logic for one byte.
module pngcsv_parser (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  pngcsv_pkg::cfg_t        cfg_i,
  input  pngcsv_pkg::step_t       step_i,
  output pngcsv_pkg::verdict_t    verdict_o
);
  import pngcsv_pkg::*;

  localparam logic [2:0] PhSig  = 3'd0;
  localparam logic [2:0] PhLen  = 3'd1;
  localparam logic [2:0] PhType = 3'd2;
  localparam logic [2:0] PhData = 3'd3;
  localparam logic [2:0] PhCrc  = 3'd4;
  localparam logic [2:0] PhDone = 3'd5;

  logic [2:0]                  phase_q, phase_d;
  logic [2:0]                  count_q, count_d;
  logic [31:0]                 length_q, length_d;
  logic [31:0]                 ctype_q, ctype_d;
  logic [LengthBits-1:0]       remain_q, remain_d;
  logic [31:0]                 crc_q, crc_d;
  logic [31:0]                 rx_crc_q, rx_crc_d;
  logic [MarkerBits-1:0]       first_q, first_d;
  logic                        header_q, header_d;
  logic [7:0]                  b;
  logic                        letters_ok;
  verdict_t                    vd;

  assign b = step_i.data_byte;

  always_comb begin
    phase_d  = phase_q;
    count_d  = count_q;
    length_d = length_q;
    ctype_d  = ctype_q;
    remain_d = remain_q;
    crc_d    = crc_q;
    rx_crc_d = rx_crc_q;
    first_d  = first_q;
    header_d = header_q;
    vd.valid       = 1'b0;
    vd.status      = StEndOk;
    vd.marker_byte = NoByte;
    letters_ok     = 1'b1;

    if (step_i.valid) begin
      case (phase_q)
        PhSig: begin
          // The signature is collected in the length and type registers.
          if (!count_q[2]) begin
            length_d = {length_q[23:0], b};
          end else begin
            ctype_d = {ctype_q[23:0], b};
          end
          if (count_q == 3'd7) begin
            if ((length_d != SigHi) || (ctype_d != SigLo)) begin
              vd.valid  = 1'b1;
              vd.status = StNotPng;
            end else begin
              ctype_d  = '0;
              phase_d  = PhLen;
              count_d  = '0;
              length_d = '0;
            end
          end else begin
            count_d = count_q + 3'd1;
          end
        end
        PhLen: begin
          length_d = {length_q[23:0], b};
          if (count_q == 3'd3) begin
            phase_d = PhType;
            count_d = '0;
            ctype_d = '0;
            crc_d   = CrcInit;
            first_d = NoByte;
          end else begin
            count_d = count_q + 3'd1;
          end
        end
        PhType: begin
          ctype_d = {ctype_q[23:0], b};
          crc_d   = crc_byte(crc_q, b);
          if (count_q == 3'd3) begin
            for (int i = 0; i < 4; i++) begin
              letters_ok = letters_ok & is_letter(ctype_d[8*i +: 8]);
            end
            if (!letters_ok) begin
              vd.valid  = 1'b1;
              vd.status = StBadType;
            end else begin
              remain_d = length_q[LengthBits-1:0];
              rx_crc_d = '0;
              count_d  = '0;
              phase_d  = (remain_d != '0) ? PhData : PhCrc;
            end
          end else begin
            count_d = count_q + 3'd1;
          end
        end
        PhData: begin
          crc_d = crc_byte(crc_q, b);
          if (remain_q == length_q[LengthBits-1:0]) begin
            first_d = {1'b0, b};
          end
          remain_d = remain_q - {{(LengthBits-1){1'b0}}, 1'b1};
          if (remain_d == '0) begin
            phase_d = PhCrc;
            count_d = '0;
          end
        end
        PhCrc: begin
          rx_crc_d = {rx_crc_q[23:0], b};
          if (count_q == 3'd3) begin
            if (rx_crc_d != ~crc_q) begin
              vd.valid  = 1'b1;
              vd.status = StCrc;
            end else if (!header_q) begin
              if (ctype_q != TypeIhdr) begin
                vd.valid  = 1'b1;
                vd.status = StNoHeader;
              end else begin
                header_d = 1'b1;
                phase_d  = PhLen;
                count_d  = '0;
                length_d = '0;
              end
            end else if (cfg_i.stop_at_marker && (ctype_q == cfg_i.marker_type)) begin
              vd.valid       = 1'b1;
              vd.status      = StMarker;
              vd.marker_byte = first_q;
            end else if (ctype_q == TypeIend) begin
              vd.valid  = 1'b1;
              vd.status = StEndOk;
            end else begin
              phase_d  = PhLen;
              count_d  = '0;
              length_d = '0;
            end
          end else begin
            count_d = count_q + 3'd1;
          end
        end
        default: begin
          // Done: bytes are dropped until the last-byte mark.
        end
      endcase

      // A file that ends without a verdict is classified by where it stopped.
      if (!vd.valid && step_i.last_byte && (phase_q != PhDone)) begin
        vd.valid = 1'b1;
        if (phase_d == PhSig) begin
          vd.status = StShortSig;
        end else if ((phase_d == PhLen) && (count_d == '0)) begin
          vd.status = StNoIend;
        end else begin
          vd.status = StShortChnk;
        end
      end

      if (vd.valid) begin
        phase_d = PhDone;
      end

      if (step_i.last_byte) begin
        phase_d  = PhSig;
        count_d  = '0;
        length_d = '0;
        ctype_d  = '0;
        remain_d = '0;
        crc_d    = CrcInit;
        rx_crc_d = '0;
        first_d  = NoByte;
        header_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhSig;
      count_q  <= '0;
      length_q <= '0;
      ctype_q  <= '0;
      remain_q <= '0;
      crc_q    <= CrcInit;
      rx_crc_q <= '0;
      first_q  <= NoByte;
      header_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      count_q  <= count_d;
      length_q <= length_d;
      ctype_q  <= ctype_d;
      remain_q <= remain_d;
      crc_q    <= crc_d;
      rx_crc_q <= rx_crc_d;
      first_q  <= first_d;
      header_q <= header_d;
    end
  end

  assign verdict_o = vd;
endmodule

// ===== design/png_chunk_stream_validator.sv =====
// Top level of the PNG chunk stream validator: input register, parser, result register, APB port.
// Flow: a byte held in the input register is parsed when the parser consumes it; its verdict,
// if any, enters the result register. Throughput: one byte per cycle unless a verdict waits on a
// stalled sink, limited by the per-byte CRC and parser state update.
// Reset (rst_ni, asynchronous, active low) empties both registers, returns the parser to
// the signature phase and loads the configuration defaults.
module png_chunk_stream_validator (
  input  logic               clk_i,
  input  logic               rst_ni,
  pngcsv_in_if.sink          in_i,
  pngcsv_out_if.source       out_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import pngcsv_pkg::*;

  cfg_t     cfg;
  step_t    step;
  verdict_t verdict;

  // Input register: holds one byte until the parser can consume it.
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;

  // Result register: holds one verdict until the sink takes the transaction.
  logic                          out_valid_q;
  logic [StatusBits-1:0]         out_status_q;
  logic signed [MarkerBits-1:0]  out_marker_q;

  logic advance;

  // The parser consumes the held byte whenever the result register has room for a
  // possible verdict, either because it is empty or because it is drained this cycle.
  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_byte_q <= in_i.data_byte;
      in_last_q <= in_i.last_byte;
    end
  end

  assign step.valid     = advance;
  assign step.data_byte = in_byte_q;
  assign step.last_byte = in_last_q;

  pngcsv_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pngcsv_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .step_i    (step),
    .verdict_o (verdict)
  );

  // A new verdict overwrites the register only when it is empty or being taken,
  // which advance already guarantees.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (verdict.valid) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (verdict.valid) begin
      out_status_q <= verdict.status;
      out_marker_q <= verdict.marker_byte;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = out_status_q;
  assign out_o.marker_byte = out_marker_q;
endmodule
